// ===== hw/rtl/modbus_rtu_response_receiver_top_macros.svh =====
// Assertion helpers for the Modbus RTU response receiver.
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_TOP_MACROS_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrr_pkg.sv =====
`default_nettype none
package mrr_pkg;

  localparam int unsigned POS_W      = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [POS_W-1:0] MAX_POSITION = 9'd275;
  localparam logic [POS_W-1:0] POS_ID       = 9'd0;
  localparam logic [POS_W-1:0] POS_FUNC     = 9'd1;
  localparam logic [POS_W-1:0] POS_LENGTH   = 9'd2;
  localparam logic [POS_W-1:0] LEN_OFFSET   = 9'd5;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STATION_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_RELOAD = 2'd2;

  localparam logic [BYTE_W-1:0] RST_STATION_ID     = 8'd1;
  localparam logic [BYTE_W-1:0] RST_FUNCTION_CODE  = 8'h04;
  localparam logic [BYTE_W-1:0] RST_TIMEOUT_RELOAD = 8'd10;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_busy;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [POS_W-1:0]  position;
    logic              frame_done;
    logic              crc_ok;
    logic [BYTE_W-1:0] payload_length;
  } out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] station_id;
    logic [BYTE_W-1:0] function_code;
    logic [BYTE_W-1:0] timeout_reload;
  } cfg_t;

  // Reflected CRC-16, one byte: eight shift steps.
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mrr_cfg.sv =====
`default_nettype none
module mrr_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [mrr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [mrr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mrr_pkg::cfg_t                           cfg
);

  mrr_pkg::cfg_t cfg_r;
  mrr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        mrr_pkg::REG_STATION_ID:     cfg_nxt.station_id     = cfg_wdata;
        mrr_pkg::REG_FUNCTION_CODE:  cfg_nxt.function_code  = cfg_wdata;
        mrr_pkg::REG_TIMEOUT_RELOAD: cfg_nxt.timeout_reload = cfg_wdata;
        default: ;  // no register there: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_id     <= mrr_pkg::RST_STATION_ID;
      cfg_r.function_code  <= mrr_pkg::RST_FUNCTION_CODE;
      cfg_r.timeout_reload <= mrr_pkg::RST_TIMEOUT_RELOAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mrr_frame.sv =====
`default_nettype none
module mrr_frame (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire mrr_pkg::in_t  item,
  input  wire mrr_pkg::cfg_t cfg,
  output mrr_pkg::out_t      res
);

  logic [mrr_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_start;
  logic [mrr_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [mrr_pkg::BYTE_W-1:0] gap_r, gap_nxt;
  logic [mrr_pkg::CRC_W-1:0]  crc_r, crc_nxt, crc_base, crc_upd;
  logic                       acc, done, ok;

  // Expired gap or overlong frame restarts before the byte is examined.
  assign pos_start = ((gap_r == '0) || (pos_r > mrr_pkg::MAX_POSITION)) ? '0 : pos_r;
  assign crc_base  = (pos_start == mrr_pkg::POS_ID) ? mrr_pkg::CRC_INIT : crc_r;
  assign crc_upd   = mrr_pkg::crc_update(crc_base, item.rx_byte);

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    gap_nxt = gap_r;
    crc_nxt = crc_r;
    acc     = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    if (item.op == mrr_pkg::OP_TICK) begin
      if (gap_r != '0) begin
        gap_nxt = gap_r - 8'd1;
      end
    end else begin
      gap_nxt = cfg.timeout_reload;
      if (item.tx_busy) begin
        pos_nxt = '0;
      end else if ((pos_start == mrr_pkg::POS_ID) && (item.rx_byte == cfg.station_id)) begin
        crc_nxt = crc_upd;
        pos_nxt = mrr_pkg::POS_FUNC;
        acc     = 1'b1;
      end else if ((pos_start == mrr_pkg::POS_FUNC) &&
                   (item.rx_byte == cfg.function_code)) begin
        crc_nxt = crc_upd;
        pos_nxt = mrr_pkg::POS_LENGTH;
        acc     = 1'b1;
      end else if (pos_start >= mrr_pkg::POS_LENGTH) begin
        crc_nxt = crc_upd;
        if (pos_start == mrr_pkg::POS_LENGTH) begin
          len_nxt = item.rx_byte;
        end
        pos_nxt = pos_start + 9'd1;
        acc     = 1'b1;
        if ((pos_nxt > mrr_pkg::POS_LENGTH) &&
            (pos_nxt == ({1'b0, len_nxt} + mrr_pkg::LEN_OFFSET))) begin
          done = 1'b1;
          ok   = (crc_upd == '0);
        end
      end else begin
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      gap_r <= '0;
      crc_r <= mrr_pkg::CRC_INIT;
    end else if (adv) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      gap_r <= gap_nxt;
      crc_r <= crc_nxt;
    end
  end

  assign res.accepted       = acc;
  assign res.position       = pos_nxt;
  assign res.frame_done     = done;
  assign res.crc_ok         = ok;
  assign res.payload_length = len_nxt;

endmodule
`default_nettype wire

// ===== hw/rtl/modbus_rtu_response_receiver_top.sv =====
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall   mrr_pkg::in_t  (op, rx_byte, tx_busy)
// out_      output     out_valid/out_stall mrr_pkg::out_t (one result per input word)
// cfg_      input      cfg_we              cfg_idx selects register, cfg_wdata
//
// One word per cycle sustained while out_stall is low; an accepted input word is held in
// the input register and then moves to the result register.
// An input register feeds the frame logic, whose byte-wide CRC step and position
// update are combinational into the result register.
// Reset (rst_n low, synchronous) clears frame state and loads register defaults.
// in_stall rises only when the input register holds a word and the result register
// is full and stalled.
`default_nettype none
`include "modbus_rtu_response_receiver_top_macros.svh"
module modbus_rtu_response_receiver_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire mrr_pkg::in_t                   in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output mrr_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mrr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mrr_pkg::cfg_t cfg;
  mrr_pkg::in_t  s1_data_r;
  logic          s1_valid_r, s1_valid_nxt;
  mrr_pkg::out_t out_data_r;
  mrr_pkg::out_t res;
  logic          out_valid_r, out_valid_nxt;
  logic          adv, in_take;

  mrr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held word when the result register is empty or draining.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  mrr_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MRR_ASSERT_NOW(a_done_needs_accept, out_valid_r && out_data_r.frame_done, out_data_r.accepted, "frame_done without accepted byte")
  `MRR_ASSERT_NOW(a_ok_needs_done, out_valid_r && out_data_r.crc_ok, out_data_r.frame_done, "crc_ok outside frame_done")
  `MRR_ASSERT_NEXT(a_adv_fills_out, s1_valid_r && (!out_valid_r || !out_stall), out_valid_r, "held word did not reach result register")
  `MRR_ASSERT_NEXT(a_tick_not_taken, adv && (s1_data_r.op == mrr_pkg::OP_TICK), !out_data_r.accepted && !out_data_r.frame_done, "tick reported as taken byte")

endmodule
`default_nettype wire
